>>> rtl/phpds_pkg.sv
package phpds_pkg;

	// default field widths
	localparam int DEF_OFFSET_BITS = 24;
	localparam int DEF_LINE_BITS   = 20;
	localparam int DEF_DEPTH_BITS  = 16;
	localparam int DEF_NAME_BUFFER = 256;

	// lookahead window
	localparam int WIN      = 9;
	localparam int FILL_W   = 4;
	localparam int KW_FN_LEN = 8;
	localparam int KW_CL_LEN = 5;

	// record kinds
	localparam logic [1:0] KIND_FUNC = 2'd0;
	localparam logic [1:0] KIND_LONG = 2'd1;
	localparam logic [1:0] KIND_SUM  = 2'd2;

	// characters
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BTICK  = 8'h60;
	localparam logic [7:0] CH_CASE   = 8'h20;

	localparam logic [KW_FN_LEN*8-1:0] KW_FN = "noitcnuf"; // byte 0 in low bits
	localparam logic [KW_CL_LEN*8-1:0] KW_CL = "ssalc";

	typedef enum logic [3:0] {
		M_SEARCH, M_KWSKIP, M_AFTERKW, M_FNAME_FIRST, M_FNAME, M_FAFTERNAME,
		M_PARAMS, M_FAFTERPARAMS, M_BODY, M_CNAME_FIRST, M_CNAME, M_CLASSEND,
		M_CLASSBRACE
	} scan_mode_t;

	typedef enum logic [2:0] {
		L_NONE, L_LINE, L_BOPEN, L_BLOCK, L_BCLOSE, L_STR, L_ESC
	} lex_mode_t;

	// byte classes at the head of the window
	typedef struct packed {
		logic blank0;
		logic nl0;
		logic alpha0;
		logic ident0;
		logic quote0;
		logic hash0;
		logic slash0;
		logic star0;
		logic lbrace0;
		logic rbrace0;
		logic lpar0;
		logic rpar0;
		logic bslash0;
		logic slash1;
		logic star1;
		logic fn_word;
		logic cl_word;
	} lex_flags_t;

endpackage

>>> rtl/phpds_classify.sv
module phpds_classify
	import phpds_pkg::*;
(
	input  logic [WIN*8-1:0] win_bytes,
	output lex_flags_t       flags
);

	logic [7:0] c;
	logic [7:0] d;
	logic       fn_ok;
	logic       cl_ok;

	assign c = win_bytes[7:0];
	assign d = win_bytes[15:8];

	// case-folded keyword compare
	always_comb begin
		fn_ok = 1'b1;
		for (int i = 0; i < KW_FN_LEN; i++) begin
			if ((win_bytes[i*8 +: 8] | CH_CASE) != KW_FN[i*8 +: 8]) fn_ok = 1'b0;
		end
		cl_ok = 1'b1;
		for (int i = 0; i < KW_CL_LEN; i++) begin
			if ((win_bytes[i*8 +: 8] | CH_CASE) != KW_CL[i*8 +: 8]) cl_ok = 1'b0;
		end
	end

	// byte classes
	always_comb begin
		flags.blank0  = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
		flags.nl0     = (c == CH_NL);
		flags.alpha0  = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
		flags.ident0  = flags.alpha0 || (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F);
		flags.quote0  = (c == CH_SQUOTE) || (c == CH_DQUOTE) || (c == CH_BTICK);
		flags.hash0   = (c == CH_HASH);
		flags.slash0  = (c == CH_SLASH);
		flags.star0   = (c == CH_STAR);
		flags.lbrace0 = (c == CH_LBRACE);
		flags.rbrace0 = (c == CH_RBRACE);
		flags.lpar0   = (c == CH_LPAR);
		flags.rpar0   = (c == CH_RPAR);
		flags.bslash0 = (c == CH_BSLASH);
		flags.slash1  = (d == CH_SLASH);
		flags.star1   = (d == CH_STAR);
		flags.fn_word = fn_ok;
		flags.cl_word = cl_ok;
	end

endmodule

>>> rtl/php_definition_scanner_core.sv
// A byte is held in a 9-byte lookahead window; the scanner works 8 bytes behind.
// Throughput: one byte per cycle while the result side accepts; a mode change that moves no byte holds the input.
// After the final byte the window drains at one step per cycle while the result side accepts,
// then the pending function record and the summary leave, in that order.
// A result request leaves in the cycle after the step that makes it.
// Reset (arst_n low, asynchronous) clears all scan state; the summary does the same.
module php_definition_scanner_core
	import phpds_pkg::*;
#(
	parameter int OFFSET_BITS = DEF_OFFSET_BITS,
	parameter int LINE_BITS   = DEF_LINE_BITS,
	parameter int DEPTH_BITS  = DEF_DEPTH_BITS,
	parameter int NAME_BUFFER = DEF_NAME_BUFFER,
	localparam int RAW_W = 7*OFFSET_BITS + 2*LINE_BITS,
	localparam int TDW   = ((RAW_W + 7) / 8) * 8
)
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [7:0]     s_tdata,   // byte_value
	input  logic           s_tlast,   // last_byte
	output logic           m_tvalid,
	input  logic           m_tready,
	// name_offset, name_length, params_offset, params_length, class_offset,
	// class_length, start_line, end_line, function_count
	output logic [TDW-1:0] m_tdata,
	output logic [1:0]     m_tuser,   // record_kind
	output logic           m_tlast    // final_record
);

	localparam int TSZ_W = (OFFSET_BITS + 2 > 13) ? OFFSET_BITS + 2 : 13;
	localparam logic [OFFSET_BITS-1:0] OMAX = '1;
	localparam logic [LINE_BITS-1:0]   LMAX = '1;
	localparam logic [DEPTH_BITS-1:0]  DMAX = '1;

	// window and step control
	logic [7:0]        win_q [WIN];
	logic [7:0]        win_n [WIN];
	logic [FILL_W-1:0] fill_q, fill_n;
	logic              drain_q, emitted_q;
	logic [WIN*8-1:0]  win_bytes;
	lex_flags_t        f;

	// scan state
	scan_mode_t             mode_q, mode_n;
	lex_mode_t              lex_q, lex_n;
	logic [3:0]             kw_left_q, kw_left_n;
	logic                   kw_cls_q, kw_cls_n;
	logic                   skipped_q, skipped_n;
	logic [7:0]             quote_q, quote_n;
	logic                   in_cls_q, in_cls_n;
	logic [OFFSET_BITS-1:0] pos_q, pos_n, pos_inc;
	logic [LINE_BITS-1:0]   line_q, line_n;
	logic [DEPTH_BITS-1:0]  depth_q, depth_n, depth_dec;
	logic [OFFSET_BITS-1:0] cls_off_q, cls_off_n, cls_len_q, cls_len_n;
	logic [OFFSET_BITS-1:0] nm_off_q, nm_off_n, nm_len_q, nm_len_n;
	logic [OFFSET_BITS-1:0] pr_off_q, pr_off_n, pr_len_q, pr_len_n;
	logic [LINE_BITS-1:0]   sline_q, sline_n;
	logic [OFFSET_BITS-1:0] count_q, count_n;

	// step decode
	logic act_en, fin_en, can_emit, go, accept;
	logic consume, line_inc, do_skip, rec, summary, rec_emit;
	logic skip_nostr, skip_str, open_m, close_m;
	logic fn_ok, cl_ok;
	logic [3:0] kw_dec;
	logic [FILL_W-1:0] wr_idx;
	logic [OFFSET_BITS-1:0] rec_coff, rec_clen;
	logic [TSZ_W-1:0] tsz;

	// output register
	logic                   out_valid_q;
	logic [1:0]             out_kind_q;
	logic [TDW-1:0]         out_data_q;
	logic                   out_last_q;
	logic [RAW_W-1:0]       rec_raw;

	always_comb begin
		for (int i = 0; i < WIN; i++) win_bytes[i*8 +: 8] = win_q[i];
	end

	phpds_classify u_classify (
		.win_bytes (win_bytes),
		.flags     (f)
	);

	assign act_en   = (fill_q == FILL_W'(WIN)) || (drain_q && fill_q != '0);
	assign fin_en   = drain_q && (fill_q == '0);
	assign can_emit = !out_valid_q || m_tready;

	assign fn_ok = f.fn_word && (fill_q >= FILL_W'(KW_FN_LEN + 1));
	assign cl_ok = f.cl_word && (fill_q >= FILL_W'(KW_CL_LEN + 1));

	assign skip_nostr = f.blank0 || f.hash0 || (f.slash0 && f.slash1) || (f.slash0 && f.star1);
	assign skip_str   = skip_nostr || f.quote0;

	assign pos_inc   = (pos_q != OMAX) ? pos_q + 1'b1 : pos_q;
	assign depth_dec = (depth_q != '0) ? depth_q - 1'b1 : depth_q;
	assign kw_dec    = (kw_left_q != '0) ? kw_left_q - 1'b1 : kw_left_q;

	// one scanner step
	always_comb begin
		mode_n = mode_q; lex_n = lex_q; kw_left_n = kw_left_q; kw_cls_n = kw_cls_q;
		skipped_n = skipped_q; quote_n = quote_q; in_cls_n = in_cls_q;
		depth_n = depth_q; cls_off_n = cls_off_q; cls_len_n = cls_len_q;
		nm_off_n = nm_off_q; nm_len_n = nm_len_q; pr_off_n = pr_off_q;
		pr_len_n = pr_len_q; sline_n = sline_q;
		consume = 1'b0; line_inc = 1'b0; do_skip = 1'b0; rec = 1'b0; summary = 1'b0;
		open_m = (mode_q == M_PARAMS) ? f.lpar0 : f.lbrace0;
		close_m = (mode_q == M_PARAMS) ? f.rpar0 : f.rbrace0;

		if (fin_en) begin
			if (mode_q == M_BODY) begin
				rec = 1'b1;
				mode_n = M_SEARCH;
			end else begin
				summary = 1'b1;
			end
		end else if (lex_q != L_NONE) begin
			unique case (lex_q)
				L_LINE: begin
					if (f.nl0) begin line_inc = 1'b1; lex_n = L_NONE; end
					consume = 1'b1;
				end
				L_BOPEN: begin consume = 1'b1; lex_n = L_BLOCK; end
				L_BLOCK: begin
					if (f.star0 && f.slash1) begin
						consume = 1'b1; lex_n = L_BCLOSE;
					end else begin
						line_inc = f.nl0; consume = 1'b1;
					end
				end
				L_BCLOSE: begin consume = 1'b1; lex_n = L_NONE; end
				L_STR: begin
					if (f.bslash0) begin
						consume = 1'b1; lex_n = L_ESC;
					end else begin
						if (f.nl0) line_inc = 1'b1;
						else if (win_q[0] == quote_q) lex_n = L_NONE;
						consume = 1'b1;
					end
				end
				L_ESC: begin line_inc = f.nl0; consume = 1'b1; lex_n = L_STR; end
				default: lex_n = L_NONE;
			endcase
		end else begin
			unique case (mode_q)
				M_SEARCH: begin
					if (skip_nostr) begin
						do_skip = 1'b1; skipped_n = 1'b1;
					end else begin
						skipped_n = 1'b0;
						priority if (skipped_q && fn_ok) begin
							kw_left_n = 4'(KW_FN_LEN); kw_cls_n = 1'b0; mode_n = M_KWSKIP;
						end else if (skipped_q && cl_ok) begin
							kw_left_n = 4'(KW_CL_LEN); kw_cls_n = 1'b1; mode_n = M_KWSKIP;
						end else if (f.quote0) begin
							quote_n = win_q[0]; consume = 1'b1; lex_n = L_STR;
						end else if (f.rbrace0 && in_cls_q) begin
							mode_n = M_CLASSEND;
						end else begin
							consume = 1'b1;
						end
					end
				end
				M_KWSKIP: begin
					consume = 1'b1;
					kw_left_n = kw_dec;
					if (kw_dec == '0) begin mode_n = M_AFTERKW; skipped_n = 1'b0; end
				end
				M_AFTERKW: begin
					if (skip_nostr) begin
						do_skip = 1'b1; skipped_n = 1'b1;
					end else if (!skipped_q) begin
						mode_n = M_SEARCH; skipped_n = 1'b0;
					end else begin
						skipped_n = 1'b0;
						if (!kw_cls_q) mode_n = M_FNAME_FIRST;
						else mode_n = in_cls_q ? M_CLASSEND : M_CNAME_FIRST;
					end
				end
				M_FNAME_FIRST: begin
					nm_off_n = pos_q; sline_n = line_q; nm_len_n = '0;
					if (f.alpha0) begin consume = 1'b1; mode_n = M_FNAME; end
					else mode_n = M_FAFTERNAME;
				end
				M_FNAME: begin
					if (f.ident0) consume = 1'b1;
					else begin nm_len_n = pos_q - nm_off_q; mode_n = M_FAFTERNAME; end
				end
				M_FAFTERNAME: begin
					if (skip_nostr) do_skip = 1'b1;
					else if (!f.lpar0) begin mode_n = M_SEARCH; skipped_n = 1'b0; end
					else begin
						pr_off_n = pos_q; consume = 1'b1; depth_n = DEPTH_BITS'(1);
						mode_n = M_PARAMS;
					end
				end
				M_FAFTERPARAMS: begin
					if (skip_nostr) do_skip = 1'b1;
					else if (!f.lbrace0) begin mode_n = M_SEARCH; skipped_n = 1'b0; end
					else begin consume = 1'b1; depth_n = DEPTH_BITS'(1); mode_n = M_BODY; end
				end
				M_PARAMS, M_BODY, M_CLASSBRACE: begin
					if (skip_str) do_skip = 1'b1;
					else if (open_m) begin
						if (depth_q != DMAX) depth_n = depth_q + 1'b1;
						consume = 1'b1;
					end else if (close_m) begin
						depth_n = depth_dec;
						consume = 1'b1;
						if (depth_dec == '0) begin
							if (mode_q == M_PARAMS) begin
								pr_len_n = pos_inc - pr_off_q; mode_n = M_FAFTERPARAMS;
							end else if (mode_q == M_BODY) begin
								rec = 1'b1; mode_n = M_SEARCH; skipped_n = 1'b0;
							end else begin
								mode_n = M_CLASSEND;
							end
						end
					end else begin
						consume = 1'b1;
					end
				end
				M_CNAME_FIRST: begin
					in_cls_n = 1'b1; cls_off_n = pos_q; cls_len_n = '0;
					if (f.alpha0) begin consume = 1'b1; mode_n = M_CNAME; end
					else begin mode_n = M_SEARCH; skipped_n = 1'b0; end
				end
				M_CNAME: begin
					if (f.ident0) consume = 1'b1;
					else begin
						cls_len_n = pos_q - cls_off_q; mode_n = M_SEARCH; skipped_n = 1'b0;
					end
				end
				M_CLASSEND: begin
					if (f.rbrace0) begin
						consume = 1'b1; in_cls_n = 1'b0; mode_n = M_SEARCH; skipped_n = 1'b0;
					end else if (f.lbrace0) begin
						consume = 1'b1; depth_n = DEPTH_BITS'(1); mode_n = M_CLASSBRACE;
					end else if (skip_str) begin
						do_skip = 1'b1;
					end else begin
						consume = 1'b1;
					end
				end
				default: begin mode_n = M_SEARCH; skipped_n = 1'b0; end
			endcase

			// blank, comment or string opener at the cursor
			if (do_skip) begin
				priority if (f.blank0) begin
					line_inc = f.nl0; consume = 1'b1;
				end else if (f.hash0 || (f.slash0 && f.slash1)) begin
					lex_n = L_LINE;
				end else if (f.slash0 && f.star1) begin
					consume = 1'b1; lex_n = L_BOPEN;
				end else begin
					quote_n = win_q[0]; consume = 1'b1; lex_n = L_STR;
				end
			end
		end
	end

	assign rec_emit = rec && !emitted_q;
	assign go       = (act_en || fin_en) && (!(rec_emit || summary) || can_emit);
	assign s_tready = !drain_q &&
		((fill_q != FILL_W'(WIN)) || (act_en && go && consume));
	assign accept   = s_tvalid && s_tready;

	// counters and window
	always_comb begin
		pos_n = pos_q; line_n = line_q; count_n = count_q; fill_n = fill_q;
		for (int i = 0; i < WIN; i++) win_n[i] = win_q[i];
		if (go && consume) begin
			for (int i = 0; i < WIN-1; i++) win_n[i] = win_q[i+1];
			win_n[WIN-1] = '0;
			fill_n = fill_q - 1'b1;
			pos_n = pos_inc;
		end
		if (go && line_inc && line_q != LMAX) line_n = line_q + 1'b1;
		if (go && rec && count_q != OMAX) count_n = count_q + 1'b1;
		wr_idx = fill_n;
		if (accept) begin
			win_n[wr_idx] = s_tdata;
			fill_n = fill_n + 1'b1;
		end
	end

	// function record fields
	assign rec_coff = in_cls_q ? cls_off_q : '0;
	assign rec_clen = in_cls_q ? cls_len_q : '0;
	assign tsz = TSZ_W'(nm_len_q) + TSZ_W'(pr_len_q) + TSZ_W'(rec_clen) + TSZ_W'(3);
	assign rec_raw = {count_n, line_q, sline_q, rec_clen, rec_coff,
		pr_len_q, pr_off_q, nm_len_q, nm_off_q};

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN; i++) win_q[i] <= '0;
			fill_q <= '0; drain_q <= 1'b0; emitted_q <= 1'b0;
			mode_q <= M_SEARCH; lex_q <= L_NONE; kw_left_q <= '0; kw_cls_q <= 1'b0;
			skipped_q <= 1'b0; quote_q <= '0; in_cls_q <= 1'b0;
			pos_q <= '0; line_q <= LINE_BITS'(1); depth_q <= '0;
			cls_off_q <= '0; cls_len_q <= '0; nm_off_q <= '0; nm_len_q <= '0;
			pr_off_q <= '0; pr_len_q <= '0; sline_q <= LINE_BITS'(1); count_q <= '0;
		end else if (go && summary) begin
			for (int i = 0; i < WIN; i++) win_q[i] <= '0;
			fill_q <= '0; drain_q <= 1'b0; emitted_q <= 1'b0;
			mode_q <= M_SEARCH; lex_q <= L_NONE; kw_left_q <= '0; kw_cls_q <= 1'b0;
			skipped_q <= 1'b0; quote_q <= '0; in_cls_q <= 1'b0;
			pos_q <= '0; line_q <= LINE_BITS'(1); depth_q <= '0;
			cls_off_q <= '0; cls_len_q <= '0; nm_off_q <= '0; nm_len_q <= '0;
			pr_off_q <= '0; pr_len_q <= '0; sline_q <= LINE_BITS'(1); count_q <= '0;
		end else begin
			for (int i = 0; i < WIN; i++) win_q[i] <= win_n[i];
			fill_q <= fill_n;
			pos_q <= pos_n; line_q <= line_n; count_q <= count_n;
			if (accept && s_tlast) drain_q <= 1'b1;
			emitted_q <= accept ? 1'b0 : (emitted_q || (go && rec_emit));
			if (go) begin
				mode_q <= mode_n; lex_q <= lex_n; kw_left_q <= kw_left_n;
				kw_cls_q <= kw_cls_n; skipped_q <= skipped_n; quote_q <= quote_n;
				in_cls_q <= in_cls_n; depth_q <= depth_n;
				cls_off_q <= cls_off_n; cls_len_q <= cls_len_n;
				nm_off_q <= nm_off_n; nm_len_q <= nm_len_n;
				pr_off_q <= pr_off_n; pr_len_q <= pr_len_n; sline_q <= sline_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && (rec_emit || summary)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && summary) begin
			out_kind_q <= KIND_SUM;
			out_data_q <= TDW'({count_q, {(RAW_W-OFFSET_BITS){1'b0}}});
			out_last_q <= 1'b1;
		end else if (go && rec_emit) begin
			out_kind_q <= (tsz > TSZ_W'(NAME_BUFFER - 1)) ? KIND_LONG : KIND_FUNC;
			out_data_q <= TDW'(rec_raw);
			out_last_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

>>> tb/sv/php_scan_checker.sv
`timescale 1ns / 100ps

module php_scan_checker
	import phpds_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [207:0] m_tdata,
	input  logic [1:0]   m_tuser,
	input  logic         m_tlast,
	output int           fail_count,
	output int           pending,
	output int           checked
);

	localparam logic [23:0] OFS_MAX = 24'hFFFFFF;
	localparam logic [19:0] LN_MAX  = 20'hFFFFF;
	localparam logic [15:0] DP_MAX  = 16'hFFFF;

	typedef struct {
		logic [1:0]  kind;
		logic [23:0] noff, nlen, poff, plen, coff, clen;
		logic [19:0] sline, eline;
		logic [23:0] cnt;
		logic        fin;
	} fn_record_t;

	fn_record_t records_due[$];

	// scanner state mirror
	scan_mode_t  mode;
	lex_mode_t   lex;
	int          kw_left;
	bit          kw_class, was_skipped;
	logic [7:0]  win [WIN];
	int          fill;
	logic [23:0] pos;
	logic [19:0] line;
	logic [15:0] depth;
	logic [7:0]  qchar;
	bit          in_class;
	logic [23:0] cls_off, cls_len, nm_off, nm_len, pr_off, pr_len, found;
	logic [19:0] st_line;
	int          step_recs;

	assign pending = records_due.size();

	function automatic void clear_scan();
		mode = M_SEARCH; lex = L_NONE; kw_left = 0; kw_class = 0; was_skipped = 0;
		for (int i = 0; i < WIN; i++) win[i] = 8'h00;
		fill = 0; pos = '0; line = 20'd1; depth = '0; qchar = '0; in_class = 0;
		cls_off = '0; cls_len = '0; nm_off = '0; nm_len = '0; pr_off = '0; pr_len = '0;
		st_line = 20'd1; found = '0;
	endfunction

	function automatic logic [7:0] at(int i);
		return (i < fill && i < WIN) ? win[i] : 8'h00;
	endfunction

	function automatic bit blank_ch(logic [7:0] c);
		return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit alpha_ch(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit ident_ch(logic [7:0] c);
		return alpha_ch(c) || (c >= "0" && c <= "9") || c == "_";
	endfunction

	function automatic bit quote_ch(logic [7:0] c);
		return c == CH_SQUOTE || c == CH_DQUOTE || c == CH_BTICK;
	endfunction

	function automatic void drop_byte();
		if (fill == 0) return;
		for (int i = 0; i < WIN - 1; i++) win[i] = win[i + 1];
		win[WIN - 1] = 8'h00;
		fill--;
		if (pos < OFS_MAX) pos++;
	endfunction

	function automatic void next_line();
		if (line < LN_MAX) line++;
	endfunction

	// keyword match, case folded; needs one byte after the word in the window
	function automatic bit keyword_at(bit is_cl);
		int n;
		logic [7:0] w;
		n = is_cl ? KW_CL_LEN : KW_FN_LEN;
		for (int i = 0; i < 2; i++) begin
			w = is_cl ? KW_CL[8*i +: 8] : KW_FN[8*i +: 8];
			if ((at(i) | CH_CASE) != w) return 0;
		end
		if (fill < n + 1) return 0;
		for (int i = 2; i < n; i++) begin
			w = is_cl ? KW_CL[8*i +: 8] : KW_FN[8*i +: 8];
			if ((at(i) | CH_CASE) != w) return 0;
		end
		return 1;
	endfunction

	function automatic void push_rec(logic [1:0] k, logic [23:0] no, nl, po, pl, co, cl,
			logic [19:0] sl, el, logic [23:0] cnt, logic fin);
		fn_record_t r;
		r.kind = k; r.noff = no; r.nlen = nl; r.poff = po; r.plen = pl;
		r.coff = co; r.clen = cl; r.sline = sl; r.eline = el; r.cnt = cnt; r.fin = fin;
		records_due.push_back(r);
		step_recs++;
	endfunction

	// only one function record per input byte
	function automatic void close_function();
		logic [23:0] co, cl;
		longint total;
		co = in_class ? cls_off : '0;
		cl = in_class ? cls_len : '0;
		total = longint'(nm_len) + longint'(pr_len) + longint'(cl) + 3;
		if (found < OFS_MAX) found++;
		if (step_recs != 0) return;
		push_rec(total > DEF_NAME_BUFFER - 1 ? KIND_LONG : KIND_FUNC, nm_off, nm_len,
			pr_off, pr_len, co, cl, st_line, line, found, 1'b0);
	endfunction

	function automatic bit skip_token(bit strings);
		logic [7:0] c, d;
		c = at(0); d = at(1);
		if (blank_ch(c)) begin
			if (c == CH_NL) next_line();
			drop_byte();
			return 1;
		end
		if (c == CH_HASH || (c == CH_SLASH && d == CH_SLASH)) begin
			lex = L_LINE;
			return 1;
		end
		if (c == CH_SLASH && d == CH_STAR) begin
			drop_byte(); lex = L_BOPEN;
			return 1;
		end
		if (strings && quote_ch(c)) begin
			qchar = c; drop_byte(); lex = L_STR;
			return 1;
		end
		return 0;
	endfunction

	function automatic void lex_advance(logic [7:0] c);
		case (lex)
			L_LINE: begin
				if (c == CH_NL) begin
					next_line(); lex = L_NONE;
				end
				drop_byte();
			end
			L_BOPEN: begin
				drop_byte(); lex = L_BLOCK;
			end
			L_BLOCK: begin
				if (c == CH_STAR && at(1) == CH_SLASH) begin
					drop_byte(); lex = L_BCLOSE;
				end else begin
					if (c == CH_NL) next_line();
					drop_byte();
				end
			end
			L_BCLOSE: begin
				drop_byte(); lex = L_NONE;
			end
			L_STR: begin
				if (c == CH_BSLASH) begin
					drop_byte(); lex = L_ESC;
				end else begin
					if (c == CH_NL) next_line();
					else if (c == qchar) lex = L_NONE;
					drop_byte();
				end
			end
			L_ESC: begin
				if (c == CH_NL) next_line();
				drop_byte(); lex = L_STR;
			end
			default: lex = L_NONE;
		endcase
	endfunction

	function automatic void back_to_search();
		mode = M_SEARCH; was_skipped = 0;
	endfunction

	// one scanner step at the head of the window
	function automatic void scan_step();
		logic [7:0] c, opener, closer;
		c = at(0);
		if (lex != L_NONE) begin
			lex_advance(c);
			return;
		end
		case (mode)
			M_SEARCH: begin
				if (skip_token(0)) begin
					was_skipped = 1;
					return;
				end
				if (was_skipped) begin
					was_skipped = 0;
					if (keyword_at(0)) begin
						kw_left = KW_FN_LEN; kw_class = 0; mode = M_KWSKIP;
						return;
					end
					if (keyword_at(1)) begin
						kw_left = KW_CL_LEN; kw_class = 1; mode = M_KWSKIP;
						return;
					end
				end
				if (quote_ch(c)) begin
					qchar = c; drop_byte(); lex = L_STR;
					return;
				end
				if (c == CH_RBRACE && in_class) begin
					mode = M_CLASSEND;
					return;
				end
				drop_byte();
			end
			M_KWSKIP: begin
				drop_byte();
				if (kw_left > 0) kw_left--;
				if (kw_left == 0) begin
					mode = M_AFTERKW; was_skipped = 0;
				end
			end
			M_AFTERKW: begin
				if (skip_token(0)) begin
					was_skipped = 1;
					return;
				end
				if (!was_skipped) begin
					back_to_search();
					return;
				end
				was_skipped = 0;
				if (!kw_class) mode = M_FNAME_FIRST;
				else mode = in_class ? M_CLASSEND : M_CNAME_FIRST;
			end
			M_FNAME_FIRST: begin
				nm_off = pos; st_line = line; nm_len = '0;
				if (alpha_ch(c)) begin
					drop_byte(); mode = M_FNAME;
				end else begin
					mode = M_FAFTERNAME;
				end
			end
			M_FNAME: begin
				if (ident_ch(c)) begin
					drop_byte();
					return;
				end
				nm_len = pos - nm_off;
				mode = M_FAFTERNAME;
			end
			M_FAFTERNAME: begin
				if (skip_token(0)) return;
				if (c != CH_LPAR) begin
					back_to_search();
					return;
				end
				pr_off = pos; drop_byte(); depth = 16'd1; mode = M_PARAMS;
			end
			M_FAFTERPARAMS: begin
				if (skip_token(0)) return;
				if (c != CH_LBRACE) begin
					back_to_search();
					return;
				end
				drop_byte(); depth = 16'd1; mode = M_BODY;
			end
			M_PARAMS, M_BODY, M_CLASSBRACE: begin
				opener = (mode == M_PARAMS) ? CH_LPAR : CH_LBRACE;
				closer = (mode == M_PARAMS) ? CH_RPAR : CH_RBRACE;
				if (skip_token(1)) return;
				if (c == opener) begin
					if (depth < DP_MAX) depth++;
				end else if (c == closer) begin
					if (depth > 0) depth--;
					if (depth == 0) begin
						drop_byte();
						if (mode == M_PARAMS) begin
							pr_len = pos - pr_off; mode = M_FAFTERPARAMS;
						end else if (mode == M_BODY) begin
							close_function(); back_to_search();
						end else begin
							mode = M_CLASSEND;
						end
						return;
					end
				end
				drop_byte();
			end
			M_CNAME_FIRST: begin
				in_class = 1; cls_off = pos; cls_len = '0;
				if (alpha_ch(c)) begin
					drop_byte(); mode = M_CNAME;
				end else begin
					back_to_search();
				end
			end
			M_CNAME: begin
				if (ident_ch(c)) begin
					drop_byte();
					return;
				end
				cls_len = pos - cls_off;
				back_to_search();
			end
			M_CLASSEND: begin
				if (c == CH_RBRACE) begin
					drop_byte(); in_class = 0; back_to_search();
					return;
				end
				if (c == CH_LBRACE) begin
					drop_byte(); depth = 16'd1; mode = M_CLASSBRACE;
					return;
				end
				if (skip_token(1)) return;
				drop_byte();
			end
			default: back_to_search();
		endcase
	endfunction

	function automatic void drain_to(int limit);
		for (int g = 0; g < 256 && fill > limit; g++) scan_step();
	endfunction

	function automatic void take_byte(logic [7:0] b, logic fin);
		step_recs = 0;
		if (fill >= WIN) drain_to(WIN - 1);
		if (fill < WIN) begin
			win[fill] = b; fill++;
		end
		if (!fin) begin
			drain_to(WIN - 1);
			return;
		end
		drain_to(0);
		if (mode == M_BODY) close_function();
		push_rec(KIND_SUM, '0, '0, '0, '0, '0, '0, '0, '0, found, 1'b1);
		clear_scan();
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		fn_record_t r;
		if (!arst_n) begin
			clear_scan();
			records_due.delete();
			fail_count <= 0;
			checked <= 0;
		end else begin
			if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				checked <= checked + 1;
				if (records_due.size() == 0) begin
					$display("%0t: result with no request pending", $realtime);
					fail_count++;
				end else begin
					r = records_due.pop_front();
					if (m_tuser != r.kind) report_mismatch("record_kind", m_tuser, r.kind);
					if (m_tdata[0 +: 24] != r.noff)
						report_mismatch("name_offset", m_tdata[0 +: 24], r.noff);
					if (m_tdata[24 +: 24] != r.nlen)
						report_mismatch("name_length", m_tdata[24 +: 24], r.nlen);
					if (m_tdata[48 +: 24] != r.poff)
						report_mismatch("params_offset", m_tdata[48 +: 24], r.poff);
					if (m_tdata[72 +: 24] != r.plen)
						report_mismatch("params_length", m_tdata[72 +: 24], r.plen);
					if (m_tdata[96 +: 24] != r.coff)
						report_mismatch("class_offset", m_tdata[96 +: 24], r.coff);
					if (m_tdata[120 +: 24] != r.clen)
						report_mismatch("class_length", m_tdata[120 +: 24], r.clen);
					if (m_tdata[144 +: 20] != r.sline)
						report_mismatch("start_line", m_tdata[144 +: 20], r.sline);
					if (m_tdata[164 +: 20] != r.eline)
						report_mismatch("end_line", m_tdata[164 +: 20], r.eline);
					if (m_tdata[184 +: 24] != r.cnt)
						report_mismatch("function_count", m_tdata[184 +: 24], r.cnt);
					if (m_tlast != r.fin) report_mismatch("final_record", m_tlast, r.fin);
				end
			end
		end
	end

endmodule

>>> tb/sv/tb_php_definition_scanner_core.sv
`timescale 1ns / 100ps

module tb_php_definition_scanner_core;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;    // byte_value
	logic         s_tlast;    // last_byte
	logic         m_tvalid;
	logic         m_tready;
	// name_offset, name_length, params_offset, params_length, class_offset,
	// class_length, start_line, end_line, function_count
	logic [207:0] m_tdata;
	logic [1:0]   m_tuser;    // record_kind
	logic         m_tlast;    // final_record

	int fail_count, pending, checked;
	int bytes_sent, scripts_sent;
	bit send_burst, recv_burst;
	int recv_hold;
	byte unsigned script[$];

	php_definition_scanner_core u_top (.*);

	php_scan_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAIL php_definition_scanner_core");
		$finish;
	end

	// result side: random hold-off after each accepted result, except in burst phases
	always @(posedge clk or negedge arst_n) begin
		logic nxt;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_hold <= 0;
			recv_burst <= 0;
		end else begin
			nxt = 1'b1;
			if ($urandom_range(0, 63) == 0) recv_burst <= ~recv_burst;
			if (recv_hold > 0) begin
				recv_hold <= recv_hold - 1;
				nxt = 1'b0;
			end else if (m_tvalid && m_tready && !recv_burst) begin
				recv_hold <= $urandom_range(0, 14);
				nxt = 1'b0;
			end
			m_tready <= nxt;
		end
	end

	task automatic send_byte(byte unsigned b, bit fin);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		if ($urandom_range(0, 40) == 0) send_burst = ~send_burst;
	endtask

	task automatic send_script();
		foreach (script[i]) send_byte(script[i], 1'b0);
		send_byte(8'h00, 1'b1);
		script.delete();
		scripts_sent++;
	endtask

	function automatic void put(string s);
		for (int i = 0; i < s.len(); i++) script.push_back(s[i]);
	endfunction

	function automatic void put_ident(int len);
		string az;
		az = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
		script.push_back(az[$urandom_range(0, 51)]);
		for (int i = 1; i < len; i++) script.push_back(az[$urandom_range(0, 62)]);
	endfunction

	function automatic void put_gap();
		case ($urandom_range(0, 7))
			0: put("\n");
			1: put("\t");
			2: put(" /* c\n } */ ");
			3: put(" # note }\n");
			4: put(" // x {\n");
			default: put(" ");
		endcase
	endfunction

	function automatic void put_keyword(bit is_cl);
		string w;
		w = is_cl ? "class" : "function";
		for (int i = 0; i < w.len(); i++)
			script.push_back($urandom_range(0, 3) == 0 ? (w[i] & 8'hDF) : w[i]);
	endfunction

	function automatic void put_body();
		int n;
		n = $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: put("$x = 1;");
				1: put("if($a){ $b(); }");
				2: put("echo '}\\'{';");
				3: put("\"a\\\"}\"");
				4: put("// }\n");
				default: put_gap();
			endcase
		end
	endfunction

	function automatic void put_function();
		put_gap();
		put_keyword(0);
		put_gap();
		if ($urandom_range(0, 9) != 0) put_ident($urandom_range(0, 19) == 0 ?
			$urandom_range(240, 270) : $urandom_range(1, 8));
		if ($urandom_range(0, 2) == 0) put_gap();
		put("(");
		if ($urandom_range(0, 1)) put("$a, $b = ')(' ");
		if ($urandom_range(0, 3) == 0) put("(x)");
		put(")");
		if ($urandom_range(0, 1)) put_gap();
		put("{");
		put_body();
		put("}");
		put_gap();
	endfunction

	function automatic void put_class();
		int n;
		put_gap();
		put_keyword(1);
		put_gap();
		put_ident($urandom_range(1, 6));
		put_gap();
		put("{");
		n = $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0) put(" { $v = '}'; } ");
			else put_function();
		end
		put("}");
		put_gap();
	endfunction

	function automatic void build_script();
		int pieces;
		pieces = $urandom_range(1, 6);
		for (int p = 0; p < pieces; p++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: put_function();
				4, 5: put_class();
				6: put("'str\\' function f(){}' ");
				7: for (int k = $urandom_range(1, 6); k > 0; k--)
					script.push_back(8'($urandom_range(1, 255)));
				default: put_gap();
			endcase
		end
		// broken tail now and then: unclosed body, string, comment or class
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0: put(" function g() { $a");
				1: put(" 'open");
				2: put(" /* open");
				default: put(" class K {");
			endcase
		end
		// noise-only script now and then
		if ($urandom_range(0, 11) == 0) begin
			script.delete();
			for (int k = $urandom_range(1, 30); k > 0; k--)
				script.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		bytes_sent = 0;
		scripts_sent = 0;
		send_burst = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty script, keyword forms, extremes of the byte, nested class, unclosed string, bare keyword
		send_script();
		put(" FUNCTION Ab_9 ($x){ }\n");
		send_script();
		put("\x80\xff\x7f function () {}");
		send_script();
		put(" class A { class B { } function m(){} }");
		send_script();
		put(" function f() { 'x");
		send_script();
		put(" function");
		send_script();

		// random scripts
		while (bytes_sent < 1150) begin
			build_script();
			send_script();
			if (scripts_sent == 10) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Scanned %0d scripts, %0d bytes in all; %0d records compared.",
			scripts_sent, bytes_sent, checked);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS php_definition_scanner_core");
		end else begin
			$display("FAIL php_definition_scanner_core");
		end
		$finish;
	end

endmodule
